### sv/window_average_and_fir_defines.svh
// Assertion macros for the window average and FIR block.
// Used by window_average_and_fir.sv; no other dependencies.
`ifndef WINDOW_AVERAGE_AND_FIR_DEFINES_SVH
`define WINDOW_AVERAGE_AND_FIR_DEFINES_SVH

// same-cycle implication
`define WAFIR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WAFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/wafir_pkg.sv
// Shared constants, codes and types for the window average and FIR block.
// No dependencies; imported by every other file except the defines header.
package wafir_pkg;

	localparam int WINDOW_SIZE = 64;
	localparam int TAP_COUNT   = 32;

	localparam int DATA_W = 16;
	localparam int FRAC_W = 15;
	localparam int CMD_W  = 2;
	localparam int IDX_W  = 5;

	localparam int WP_W   = $clog2(WINDOW_SIZE);
	localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
	localparam int SUM_W  = DATA_W + $clog2(WINDOW_SIZE) + 1;
	localparam int CA_W   = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
	localparam int TC_W   = $clog2(TAP_COUNT + 1);
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT) + 1;
	localparam int DC_W   = $clog2(SUM_W + 1);

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic signed [DATA_W-1:0] sample_t;

	localparam cmd_t CMD_ADD   = 2'd0;
	localparam cmd_t CMD_LOAD  = 2'd1;
	localparam cmd_t CMD_CLEAR = 2'd2;

	localparam logic signed [ACC_W-1:0] FIR_MAX   = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] FIR_MIN   = ACC_W'(-32768);
	localparam logic signed [ACC_W-1:0] FIR_ROUND = ACC_W'((1 << FRAC_W) - 1);

	typedef struct packed {
		logic clr;
		logic vld;
	} mac_ctl_t;

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [FILL_W-1:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

### sv/wafir_ifs.sv
// Request and result channel interfaces for the window average and FIR block.
// Depends on wafir_pkg.
interface wafir_req_if import wafir_pkg::*; ();
	logic             valid;
	logic             ready;
	cmd_t             command;
	sample_t          sample;
	logic [IDX_W-1:0] coef_index;
	sample_t          coef_value;

	modport source (output valid, command, sample, coef_index, coef_value, input ready);
	modport sink (input valid, command, sample, coef_index, coef_value, output ready);
endinterface

interface wafir_res_if import wafir_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t average;
	sample_t filtered;
	logic    passthrough;

	modport source (output valid, average, filtered, passthrough, input ready);
	modport sink (input valid, average, filtered, passthrough, output ready);
endinterface

### sv/window_average_and_fir.sv
// Top level of the window average and FIR block: sequencer, sample ring, kernel table.
// Depends on wafir_pkg, wafir_ifs, wafir_mac, wafir_div and the defines header.
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------------------------
//  cmd_ch   | in  | command, sample, coef_index, coef_value
//  res_ch   | out | average, filtered, passthrough
//
// Load, clear and unused requests are handled in the idle state, which stays ready. An
// add-sample request holds the input through update, start, the MAC issues and their drain,
// then the output state, which stalls while the result register is full.
// While fewer than TAP_COUNT samples are held, no taps are issued and the divider sets the pace.
// Reset clears the window and the kernel valid bits at once; no clearing pass.
// The result register lets the next request in while a result waits; the
// sequencer holds only when a new result meets a full result register.
`include "window_average_and_fir_defines.svh"

module window_average_and_fir import wafir_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	wafir_req_if.sink   cmd_ch,
	wafir_res_if.source res_ch
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UPD   = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_RUN   = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]              state_q;
	logic [WP_W-1:0]         wp_q;
	logic [WP_W-1:0]         pos_q;
	logic [FILL_W-1:0]       fill_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_nx;
	logic [TC_W-1:0]         tap_q;
	logic                    pass_q;
	sample_t                 sample_q;

	sample_t                 ring_mem [WINDOW_SIZE];
	sample_t                 ring_rd_s1;
	sample_t                 coef_mem [TAP_COUNT];
	logic [TAP_COUNT-1:0]    coef_vld_q;
	sample_t                 coef_rd_s1;
	logic                    coef_hit_s1;
	logic                    rd_vld_s1;

	logic                    res_vld_q;
	sample_t                 avg_q;
	sample_t                 filt_q;
	logic                    pass_out_q;

	logic                    accept;
	logic                    issue;
	logic                    ring_re;
	logic [WP_W-1:0]         ring_ra;
	logic                    coef_we;
	logic [CA_W-1:0]         coef_wa;
	logic                    full;
	logic                    out_free;
	logic                    run_done;

	mac_ctl_t                mac_ctl;
	sample_t                 mac_b;
	logic signed [ACC_W-1:0] mac_acc;
	logic                    mac_busy;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	logic signed [ACC_W-1:0] fir_biased;
	logic signed [ACC_W-1:0] fir_shift;
	sample_t                 fir_sat;

	assign accept   = cmd_ch.valid && cmd_ch.ready;
	assign cmd_ch.ready = state_q == S_IDLE;
	assign issue    = state_q == S_RUN && !pass_q && tap_q < TC_W'(TAP_COUNT);
	assign ring_re  = (accept && cmd_ch.command == CMD_ADD) || issue;
	assign ring_ra  = issue ? pos_q : wp_q;
	assign coef_we  = accept && cmd_ch.command == CMD_LOAD && int'(cmd_ch.coef_index) < TAP_COUNT;
	assign coef_wa  = CA_W'(cmd_ch.coef_index);
	assign full     = fill_q == FILL_W'(WINDOW_SIZE);
	assign out_free = !res_vld_q || res_ch.ready;
	assign run_done = (pass_q || tap_q == TC_W'(TAP_COUNT)) && !rd_vld_s1 && !mac_busy
		&& div_rsp.done;

	always_comb begin
		sum_nx = sum_q + SUM_W'(sample_q);
		if (full) begin
			sum_nx = sum_nx - SUM_W'(ring_rd_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			ring_mem[wp_q] <= sample_q;
		end
		if (ring_re) begin
			ring_rd_s1 <= ring_mem[ring_ra];
		end
		if (coef_we) begin
			coef_mem[coef_wa] <= cmd_ch.coef_value;
		end
		if (issue) begin
			coef_rd_s1  <= coef_mem[tap_q[CA_W-1:0]];
			coef_hit_s1 <= coef_vld_q[tap_q[CA_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (coef_we) begin
				coef_vld_q[coef_wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q    <= '0;
			pos_q   <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			tap_q   <= '0;
			pass_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (cmd_ch.command)
							CMD_ADD: state_q <= S_UPD;
							CMD_CLEAR: begin
								wp_q   <= '0;
								fill_q <= '0;
								sum_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				S_UPD: begin
					sum_q <= sum_nx;
					if (!full) begin
						fill_q <= fill_q + 1'b1;
					end
					wp_q    <= (wp_q == WP_W'(WINDOW_SIZE - 1)) ? '0 : wp_q + 1'b1;
					pos_q   <= wp_q;
					state_q <= S_START;
				end
				S_START: begin
					pass_q  <= int'(fill_q) < TAP_COUNT;
					tap_q   <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (issue) begin
						pos_q <= (pos_q == '0) ? WP_W'(WINDOW_SIZE - 1) : pos_q - 1'b1;
						tap_q <= tap_q + 1'b1;
					end
					if (run_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd_ch.command == CMD_ADD) begin
			sample_q <= cmd_ch.sample;
		end
	end

	assign mac_ctl.clr = state_q == S_START;
	assign mac_ctl.vld = rd_vld_s1;
	assign mac_b       = coef_hit_s1 ? coef_rd_s1 : '0;

	wafir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (ring_rd_s1),
		.b      (mac_b),
		.acc    (mac_acc),
		.busy   (mac_busy)
	);

	assign div_req.start    = state_q == S_START;
	assign div_req.dividend = sum_q;
	assign div_req.divisor  = fill_q;

	wafir_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		fir_biased = mac_acc[ACC_W-1] ? mac_acc + FIR_ROUND : mac_acc;
		fir_shift  = fir_biased >>> FRAC_W;
		if (fir_shift > FIR_MAX) begin
			fir_sat = sample_t'(FIR_MAX);
		end else if (fir_shift < FIR_MIN) begin
			fir_sat = sample_t'(FIR_MIN);
		end else begin
			fir_sat = fir_shift[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			res_vld_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			avg_q      <= div_rsp.quotient[DATA_W-1:0];
			filt_q     <= pass_q ? sample_q : fir_sat;
			pass_out_q <= pass_q;
		end
	end

	assign res_ch.valid       = res_vld_q;
	assign res_ch.average     = avg_q;
	assign res_ch.filtered    = filt_q;
	assign res_ch.passthrough = pass_out_q;

	`WAFIR_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_W'(WINDOW_SIZE), "fill count beyond window")
	`WAFIR_ASSERT_NEXT(a_add_starts, clk, arst_n, accept && cmd_ch.command == CMD_ADD, state_q == S_UPD, "add request did not start update")
	`WAFIR_ASSERT_NEXT(a_out_load, clk, arst_n, state_q == S_OUT && out_free, res_vld_q && state_q == S_IDLE, "result not loaded")
	`WAFIR_ASSERT_NOW(a_mac_only_run, clk, arst_n, rd_vld_s1, !pass_q && state_q == S_RUN, "tap read outside filter pass")

endmodule

### sv/wafir_mac.sv
// Multiply-accumulate unit: one registered 16x16 product per cycle.
// Depends on wafir_pkg.
module wafir_mac import wafir_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctl_t                ctl,
	input  sample_t                 a,
	input  sample_t                 b,
	output logic signed [ACC_W-1:0] acc,
	output logic                    busy
);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     prod_vld_s1;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			prod_s1 <= a * b;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	assign acc  = acc_q;
	assign busy = prod_vld_s1;

endmodule

### sv/wafir_div.sv
// Serial restoring divider: signed sum over unsigned fill count, one bit a cycle.
// Depends on wafir_pkg.
module wafir_div import wafir_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DC_W-1:0]   cnt_q;
	logic [FILL_W-1:0] rem_q;
	logic [FILL_W-1:0] dvs_q;
	logic [SUM_W-1:0]  quo_q;
	logic              neg_q;
	logic [FILL_W:0]   trial;
	logic              take;
	logic [SUM_W-1:0]  mag;

	assign mag   = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DC_W'(SUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DC_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= mag;
			neg_q <= req.dividend[SUM_W-1];
		end else if (busy_q) begin
			rem_q <= take ? FILL_W'(trial - {1'b0, dvs_q}) : trial[FILL_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], take};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

### tb/tb_window_average_and_fir.sv
`timescale 1ns / 100ps
// Self-checking testbench for window_average_and_fir: a directed stimulus table, then random
// requests under four handshake-pressure phases, each result checked by predictor or table.
// Depends on wafir_pkg, the wafir_ifs interfaces and the window_average_and_fir RTL.

module tb_window_average_and_fir;
	import wafir_pkg::*;

	localparam cmd_t CMD_UNUSED   = 2'd3;
	localparam int   PHASE_ITEMS  = 100;
	localparam int   DRAIN_CYCLES = 120;
	localparam int   CYCLE_LIMIT  = 600000;

	typedef struct {
		cmd_t             command;
		sample_t          sample;
		logic [IDX_W-1:0] coef_index;
		sample_t          coef_value;
	} request_t;

	typedef struct {
		sample_t average;
		sample_t filtered;
		logic    passthrough;
	} filter_out_t;

	typedef struct {
		request_t    req;
		int          repeats;
		bit          typed;
		filter_out_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	wafir_req_if cmd_ch ();
	wafir_res_if res_ch ();

	window_average_and_fir dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	sample_t     win_ring [WINDOW_SIZE];
	int          win_wp;
	int          win_fill;
	longint      win_sum;
	sample_t     kernel [TAP_COUNT];
	filter_out_t expected_out [$];
	stim_row_t   stim_table [$];
	int          src_idle_pct;
	int          sink_stall_pct;
	int          failures;
	int          cycle_count;

	function automatic sample_t saturate(input longint v);
		if (v > 32767) begin
			return sample_t'(32767);
		end
		if (v < -32768) begin
			return sample_t'(-32768);
		end
		return sample_t'(v);
	endfunction

	// Advance the window and kernel for one accepted request; return 1 when it yields a result.
	function automatic bit predict(input request_t r, output filter_out_t o);
		longint acc;
		int     newest;
		int     pos;
		o.average     = '0;
		o.filtered    = '0;
		o.passthrough = 1'b0;
		if (r.command == CMD_LOAD) begin
			if (int'(r.coef_index) < TAP_COUNT) begin
				kernel[r.coef_index] = r.coef_value;
			end
			return 1'b0;
		end
		if (r.command == CMD_CLEAR) begin
			win_wp   = 0;
			win_fill = 0;
			win_sum  = 0;
			return 1'b0;
		end
		if (r.command != CMD_ADD) begin
			return 1'b0;
		end
		if (win_fill >= WINDOW_SIZE) begin
			win_sum -= longint'(win_ring[win_wp]);
		end else begin
			win_fill++;
		end
		win_ring[win_wp] = r.sample;
		win_sum += longint'(r.sample);
		newest = win_wp;
		win_wp = (win_wp + 1) % WINDOW_SIZE;
		o.average = saturate(win_sum / longint'(win_fill));
		if (win_fill < TAP_COUNT) begin
			o.filtered    = r.sample;
			o.passthrough = 1'b1;
		end else begin
			acc = 0;
			for (int j = 0; j < TAP_COUNT; j++) begin
				pos = (newest + WINDOW_SIZE - (j % WINDOW_SIZE)) % WINDOW_SIZE;
				acc += longint'(win_ring[pos]) * longint'(kernel[j]);
			end
			o.filtered = saturate(acc / 32768);
		end
		return 1'b1;
	endfunction

	function automatic sample_t any_value();
		case ($urandom_range(7))
			0: begin
				return sample_t'(32767);
			end
			1: begin
				return sample_t'(-32768);
			end
			2: begin
				return sample_t'(0);
			end
			3: begin
				return sample_t'(-1);
			end
			4, 5: begin
				return sample_t'(int'($urandom_range(511)) - 256);
			end
			default: begin
				return sample_t'($urandom);
			end
		endcase
	endfunction

	task automatic row(input cmd_t c, input sample_t s, input logic [IDX_W-1:0] idx,
			input sample_t v, input int n);
		stim_row_t e;
		e.req.command    = c;
		e.req.sample     = s;
		e.req.coef_index = idx;
		e.req.coef_value = v;
		e.repeats        = n;
		e.typed          = 1'b0;
		e.want.average     = '0;
		e.want.filtered    = '0;
		e.want.passthrough = 1'b0;
		stim_table = {stim_table, e};
	endtask

	task automatic typed_row(input sample_t s, input sample_t avg, input sample_t filt,
			input logic pass);
		stim_row_t e;
		e.req.command      = CMD_ADD;
		e.req.sample       = s;
		e.req.coef_index   = '0;
		e.req.coef_value   = '0;
		e.repeats          = 1;
		e.typed            = 1'b1;
		e.want.average     = avg;
		e.want.filtered    = filt;
		e.want.passthrough = pass;
		stim_table = {stim_table, e};
	endtask

	// Drive one request from the falling edge, hold it until taken, then predict its result.
	task automatic send_request(input request_t r, input bit typed, input filter_out_t want);
		filter_out_t got;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_ch.valid      = 1'b0;
			cmd_ch.command    = cmd_t'($urandom);
			cmd_ch.sample     = sample_t'($urandom);
			cmd_ch.coef_index = IDX_W'($urandom);
			cmd_ch.coef_value = sample_t'($urandom);
			@(negedge clk);
		end
		cmd_ch.valid      = 1'b1;
		cmd_ch.command    = r.command;
		cmd_ch.sample     = r.sample;
		cmd_ch.coef_index = r.coef_index;
		cmd_ch.coef_value = r.coef_value;
		do @(posedge clk); while (!cmd_ch.ready);
		if (predict(r, got)) begin
			if (typed) begin
				got = want;
			end
			expected_out = {expected_out, got};
		end
	endtask

	task automatic run_phase(input int idle, input int stall);
		request_t    r;
		filter_out_t none;
		int          issued;
		int          pick;
		src_idle_pct   = idle;
		sink_stall_pct = stall;
		issued         = 0;
		none.average     = '0;
		none.filtered    = '0;
		none.passthrough = 1'b0;
		while (issued < PHASE_ITEMS) begin
			pick         = $urandom_range(99);
			r.command    = CMD_ADD;
			r.sample     = any_value();
			r.coef_index = IDX_W'($urandom);
			r.coef_value = any_value();
			if (pick < 10) begin
				r.command = CMD_LOAD;
			end else if (pick < 12) begin
				r.command = CMD_UNUSED;
			end else if (pick < 13) begin
				r.command = CMD_CLEAR;
			end
			send_request(r, 1'b0, none);
			if (r.command != CMD_UNUSED) begin
				issued++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		filter_out_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_out.size() == 0) begin
				$error("unexpected result: average %0d filtered %0d passthrough %0b",
					res_ch.average, res_ch.filtered, res_ch.passthrough);
				failures++;
			end else begin
				want = expected_out.pop_front();
				if (res_ch.average !== want.average) begin
					$error("average: expected %0d, got %0d", want.average, res_ch.average);
					failures++;
				end
				if (res_ch.filtered !== want.filtered) begin
					$error("filtered: expected %0d, got %0d", want.filtered, res_ch.filtered);
					failures++;
				end
				if (res_ch.passthrough !== want.passthrough) begin
					$error("passthrough: expected %0b, got %0b", want.passthrough,
						res_ch.passthrough);
					failures++;
				end
			end
		end
	end

	initial begin
		failures          = 0;
		src_idle_pct      = 0;
		sink_stall_pct    = 0;
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.command    = CMD_ADD;
		cmd_ch.sample     = '0;
		cmd_ch.coef_index = '0;
		cmd_ch.coef_value = '0;
		win_wp   = 0;
		win_fill = 0;
		win_sum  = 0;
		foreach (win_ring[i]) begin
			win_ring[i] = '0;
		end
		foreach (kernel[i]) begin
			kernel[i] = '0;
		end

		typed_row(32767, 32767, 32767, 1'b1);
		typed_row(-32768, 0, -32768, 1'b1);
		row(CMD_CLEAR, 0, 0, 0, 1);
		typed_row(-32768, -32768, -32768, 1'b1);
		typed_row(-1, -16384, -1, 1'b1);
		row(CMD_UNUSED, -1, 31, -1, 1);
		row(CMD_LOAD, 0, 0, -32768, 1);
		row(CMD_LOAD, 0, 31, 32767, 1);
		row(CMD_ADD, 32767, 0, 0, 40);
		row(CMD_LOAD, 0, 0, 32767, TAP_COUNT);
		row(CMD_ADD, 32767, 0, 0, 70);
		row(CMD_LOAD, 0, 0, -32768, TAP_COUNT);
		row(CMD_ADD, -32768, 0, 0, 70);
		row(CMD_ADD, 32767, 0, 0, 33);
		row(CMD_LOAD, 0, 0, 0, TAP_COUNT);
		row(CMD_LOAD, 0, 0, -32768, 1);
		row(CMD_ADD, -32768, 0, 0, 1);
		row(CMD_ADD, 1, 0, 0, 1);
		row(CMD_LOAD, 0, 0, 16384, 1);
		row(CMD_ADD, -3, 0, 0, 1);
		row(CMD_ADD, 3, 0, 0, 1);
		row(CMD_CLEAR, 0, 0, 0, 1);
		row(CMD_ADD, 5, 0, 0, TAP_COUNT);
		row(CMD_ADD, -7, 0, 0, 40);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_table[i]) begin
			for (int k = 0; k < stim_table[i].repeats; k++) begin
				request_t r;
				r = stim_table[i].req;
				r.coef_index = r.coef_index + IDX_W'(k);
				send_request(r, stim_table[i].typed, stim_table[i].want);
			end
		end

		run_phase(0, 0);
		run_phase(87, 0);
		run_phase(0, 87);
		run_phase(38, 38);

		@(negedge clk);
		cmd_ch.valid = 1'b0;
		while (expected_out.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
